// ===== design/fsp_pkg.sv =====
// Package for the conversion-spec parser: item types, parser state and character codes.
// No dependencies; fsp_step and format_spec_parser refer to it by scoped names.
package fsp_pkg;

    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_LOW_C   = 8'h63;
    localparam logic [7:0] CH_LOW_S   = 8'h73;
    localparam logic [7:0] CH_LOW_P   = 8'h70;
    localparam logic [7:0] CH_LOW_D   = 8'h64;
    localparam logic [7:0] CH_LOW_I   = 8'h69;
    localparam logic [7:0] CH_LOW_U   = 8'h75;
    localparam logic [7:0] CH_LOW_X   = 8'h78;
    localparam logic [7:0] CH_UP_X    = 8'h58;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_NUL     = 8'h00;

    localparam logic [30:0] MAX31 = 31'h7FFF_FFFF;

    typedef enum logic [3:0] {
        SPEC_C       = 4'd0,
        SPEC_S       = 4'd1,
        SPEC_P       = 4'd2,
        SPEC_DI      = 4'd3,
        SPEC_U       = 4'd4,
        SPEC_LOW_X   = 4'd5,
        SPEC_UP_X    = 4'd6,
        SPEC_NUL     = 4'd7,
        SPEC_PERCENT = 4'd8,
        SPEC_OTHER   = 4'd9
    } spec_code_t;

    typedef enum logic [6:0] {
        PH_IDLE   = 7'b0000001,
        PH_FLAGS  = 7'b0000010,
        PH_WDIG   = 7'b0000100,
        PH_AFTERW = 7'b0001000,
        PH_PSTART = 7'b0010000,
        PH_PDIG   = 7'b0100000,
        PH_AFTERP = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic [7:0]         ch;
        logic signed [31:0] star_value;
    } in_item_t;

    typedef struct packed {
        logic [3:0]         spec_code;
        logic               left_align;
        logic               zero_pad;
        logic               has_width;
        logic [30:0]        width;
        logic               has_precision;
        logic signed [31:0] precision;
        logic               overflow_error;
    } out_item_t;

    typedef struct packed {
        phase_t      phase;
        logic        left_flag;
        logic        zero_flag;
        logic        width_given;
        logic [30:0] width_acc;
        logic        prec_given;
        logic [31:0] prec_acc;
    } parse_state_t;

endpackage

// ===== design/fsp_chan_if.sv =====
// Valid/ready channel carrying one payload struct per transfer.
// Payload types come from fsp_pkg.
interface fsp_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/fsp_step.sv =====
// One parser step: next state and optional result for one character.
// Depends on fsp_pkg for state, item types and character codes.
module fsp_step (
    input  fsp_pkg::parse_state_t cur,
    input  fsp_pkg::in_item_t     item,
    output fsp_pkg::parse_state_t nxt,
    output logic                  emit,
    output fsp_pkg::out_item_t    res
);
    logic        is_digit;
    logic [3:0]  digit;
    logic [30:0] acc_in;
    logic [34:0] acc_sum;
    logic        acc_ovf;
    logic [31:0] star;
    logic [30:0] star_mag;
    logic        do_spec;
    logic        do_ovf;
    logic [3:0]  code;

    assign star     = item.star_value;
    assign is_digit = (item.ch >= fsp_pkg::CH_ZERO) && (item.ch <= fsp_pkg::CH_NINE);
    assign digit    = 4'(item.ch - fsp_pkg::CH_ZERO);

    // acc*10 + d as two shifted adds; anything above bit 30 is overflow
    assign acc_in  = (cur.phase == fsp_pkg::PH_PDIG) ? cur.prec_acc[30:0] : cur.width_acc;
    assign acc_sum = {1'b0, acc_in, 3'b000} + {3'b000, acc_in, 1'b0} + {31'd0, digit};
    assign acc_ovf = |acc_sum[34:31];

    // most negative star saturates
    assign star_mag = (star == 32'h8000_0000) ? fsp_pkg::MAX31 : 31'(32'd0 - star);

    always_comb
    begin
        unique case (item.ch)
            fsp_pkg::CH_LOW_C:   code = fsp_pkg::SPEC_C;
            fsp_pkg::CH_LOW_S:   code = fsp_pkg::SPEC_S;
            fsp_pkg::CH_LOW_P:   code = fsp_pkg::SPEC_P;
            fsp_pkg::CH_LOW_D,
            fsp_pkg::CH_LOW_I:   code = fsp_pkg::SPEC_DI;
            fsp_pkg::CH_LOW_U:   code = fsp_pkg::SPEC_U;
            fsp_pkg::CH_LOW_X:   code = fsp_pkg::SPEC_LOW_X;
            fsp_pkg::CH_UP_X:    code = fsp_pkg::SPEC_UP_X;
            fsp_pkg::CH_NUL:     code = fsp_pkg::SPEC_NUL;
            fsp_pkg::CH_PERCENT: code = fsp_pkg::SPEC_PERCENT;
            default:             code = fsp_pkg::SPEC_OTHER;
        endcase
    end

    always_comb
    begin
        nxt     = cur;
        do_spec = 1'b0;
        do_ovf  = 1'b0;
        unique case (cur.phase)
            fsp_pkg::PH_FLAGS:
            begin
                priority if (item.ch == fsp_pkg::CH_MINUS)
                begin
                    nxt.left_flag = 1'b1;
                end
                else if (item.ch == fsp_pkg::CH_ZERO)
                begin
                    nxt.zero_flag = 1'b1;
                end
                else if (item.ch == fsp_pkg::CH_STAR)
                begin
                    nxt.width_given = 1'b1;
                    nxt.phase       = fsp_pkg::PH_AFTERW;
                    if (star[31])
                    begin
                        nxt.left_flag = 1'b1;
                        nxt.width_acc = star_mag;
                    end
                    else
                    begin
                        nxt.width_acc = star[30:0];
                    end
                end
                else if (is_digit)
                begin
                    nxt.width_given = 1'b1;
                    nxt.width_acc   = {27'd0, digit};
                    nxt.phase       = fsp_pkg::PH_WDIG;
                end
                else if (item.ch == fsp_pkg::CH_DOT)
                begin
                    nxt.phase = fsp_pkg::PH_PSTART;
                end
                else
                begin
                    do_spec = 1'b1;
                end
            end
            fsp_pkg::PH_WDIG:
            begin
                priority if (is_digit)
                begin
                    if (acc_ovf)
                    begin
                        do_ovf = 1'b1;
                    end
                    else
                    begin
                        nxt.width_acc = acc_sum[30:0];
                    end
                end
                else if (item.ch == fsp_pkg::CH_DOT)
                begin
                    nxt.phase = fsp_pkg::PH_PSTART;
                end
                else
                begin
                    do_spec = 1'b1;
                end
            end
            fsp_pkg::PH_AFTERW:
            begin
                if (item.ch == fsp_pkg::CH_DOT)
                begin
                    nxt.phase = fsp_pkg::PH_PSTART;
                end
                else
                begin
                    do_spec = 1'b1;
                end
            end
            fsp_pkg::PH_PSTART:
            begin
                priority if (item.ch == fsp_pkg::CH_STAR)
                begin
                    nxt.prec_acc   = star;
                    nxt.prec_given = ~star[31];
                    nxt.phase      = fsp_pkg::PH_AFTERP;
                end
                else if (is_digit)
                begin
                    nxt.prec_given = 1'b1;
                    nxt.prec_acc   = {28'd0, digit};
                    nxt.phase      = fsp_pkg::PH_PDIG;
                end
                else
                begin
                    // empty precision reads as zero
                    nxt.prec_given = 1'b1;
                    nxt.prec_acc   = 32'd0;
                    do_spec        = 1'b1;
                end
            end
            fsp_pkg::PH_PDIG:
            begin
                if (is_digit)
                begin
                    if (acc_ovf)
                    begin
                        do_ovf = 1'b1;
                    end
                    else
                    begin
                        nxt.prec_acc = {1'b0, acc_sum[30:0]};
                    end
                end
                else
                begin
                    do_spec = 1'b1;
                end
            end
            fsp_pkg::PH_AFTERP:
            begin
                do_spec = 1'b1;
            end
            default:
            begin
                // introducer: byte itself is not checked
                nxt.left_flag   = 1'b0;
                nxt.zero_flag   = 1'b0;
                nxt.width_given = 1'b0;
                nxt.width_acc   = '0;
                nxt.prec_given  = 1'b0;
                nxt.prec_acc    = '0;
                nxt.phase       = fsp_pkg::PH_FLAGS;
            end
        endcase

        res                = '0;
        res.spec_code      = fsp_pkg::SPEC_OTHER;
        res.overflow_error = do_ovf;
        if (do_spec)
        begin
            res.spec_code     = code;
            res.left_align    = nxt.left_flag;
            res.zero_pad      = nxt.zero_flag;
            res.has_width     = nxt.width_given;
            res.width         = nxt.width_acc;
            res.has_precision = nxt.prec_given;
            res.precision     = nxt.prec_acc;
        end

        if (do_ovf)
        begin
            nxt.left_flag   = 1'b0;
            nxt.zero_flag   = 1'b0;
            nxt.width_given = 1'b0;
            nxt.width_acc   = '0;
            nxt.prec_given  = 1'b0;
            nxt.prec_acc    = '0;
        end
        if (do_spec || do_ovf)
        begin
            nxt.phase = fsp_pkg::PH_IDLE;
        end
        emit = do_spec | do_ovf;
    end
endmodule

// ===== design/format_spec_parser.sv =====
// Top level of the printf conversion-spec parser: input register, parser state, result register.
// Depends on fsp_pkg, fsp_chan_if and fsp_step.
//
//   channel  role    payload                      transfer when
//   chars    sink    ch, star_value               chars.valid && chars.ready
//   specs    source  spec_code .. overflow_error  specs.valid && specs.ready
//
// One character per cycle. A character is registered, then stepped through the
// parser; its result, if any, is registered in the result register and put on specs.
// The digit accumulate (times ten plus digit, with overflow test) sets the cycle.
// Reset returns the parser to awaiting an introducer and empties both registers.
// While a result waits on specs, a character that ends a spec holds in the input
// register and stops chars; characters that end nothing keep flowing.
module format_spec_parser (
    input  logic        clk,
    input  logic        rst_n,
    fsp_chan_if.sink    chars,
    fsp_chan_if.source  specs
);
    fsp_pkg::in_item_t     in_reg;
    logic                  in_valid_reg;
    fsp_pkg::parse_state_t state_reg;
    fsp_pkg::parse_state_t state_next;
    fsp_pkg::out_item_t    out_reg;
    fsp_pkg::out_item_t    out_next;
    logic                  out_valid_reg;
    logic                  emit;
    logic                  advance;

    fsp_step u_step (
        .cur  (state_reg),
        .item (in_reg),
        .nxt  (state_next),
        .emit (emit),
        .res  (out_next)
    );

    assign advance     = in_valid_reg & (~emit | ~out_valid_reg | specs.ready);
    assign chars.ready = ~in_valid_reg | advance;
    assign specs.valid = out_valid_reg;
    assign specs.data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg          <= 1'b0;
            out_valid_reg         <= 1'b0;
            state_reg.phase       <= fsp_pkg::PH_IDLE;
            state_reg.left_flag   <= 1'b0;
            state_reg.zero_flag   <= 1'b0;
            state_reg.width_given <= 1'b0;
            state_reg.width_acc   <= '0;
            state_reg.prec_given  <= 1'b0;
            state_reg.prec_acc    <= '0;
        end
        else
        begin
            if (chars.ready)
            begin
                in_valid_reg <= chars.valid;
            end
            if (advance)
            begin
                state_reg <= state_next;
            end
            if (advance && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (specs.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (chars.valid && chars.ready)
        begin
            in_reg <= chars.data;
        end
        if (advance && emit)
        begin
            out_reg <= out_next;
        end
    end
endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// Testbench for format_spec_parser: directed spec strings, then random specs and noise.
// Depends on fsp_pkg, fsp_chan_if, parser RTL; checks each result by predictor or typed row.
module testbench;

    localparam int CHAR_COUNT  = 650;
    localparam int CYCLE_LIMIT = 200000;
    localparam int TAIL_CYCLES = 20;

    typedef struct {
        logic [7:0]         ch;
        logic [31:0]        star;
        bit                 typed;
        fsp_pkg::out_item_t want;
    } dir_row_t;

    logic clk;
    logic rst_n;

    fsp_chan_if #(.payload_t(fsp_pkg::in_item_t))  chars_if ();
    fsp_chan_if #(.payload_t(fsp_pkg::out_item_t)) specs_if ();

    format_spec_parser dut (
        .clk   (clk),
        .rst_n (rst_n),
        .chars (chars_if),
        .specs (specs_if)
    );

    // parser state as the predictor sees it
    fsp_pkg::phase_t parse_phase = fsp_pkg::PH_IDLE;
    logic            spec_left   = 1'b0;
    logic            spec_zero   = 1'b0;
    logic            width_seen  = 1'b0;
    logic [30:0]     width_val   = '0;
    logic            prec_seen   = 1'b0;
    logic [31:0]     prec_val    = '0;

    fsp_pkg::out_item_t pending_specs[$];
    int        chars_sent  = 0;
    int        specs_seen  = 0;
    int        mismatches  = 0;
    int        cycles      = 0;

    // width overflow, star edge values, empty precision, flag after width, NUL specifier
    dir_row_t directed [26] = '{
        '{fsp_pkg::CH_PERCENT,     32'hFFFF_FFFF, 1'b0, '0},
        '{fsp_pkg::CH_LOW_D,       32'h0000_0000, 1'b1,
          fsp_pkg::out_item_t'{fsp_pkg::SPEC_DI, 1'b0, 1'b0, 1'b0, 31'd0, 1'b0,
                               32'd0, 1'b0}},
        '{8'hFF,                   32'h7FFF_FFFF, 1'b0, '0},
        '{fsp_pkg::CH_MINUS,       32'h0000_0000, 1'b0, '0},
        '{fsp_pkg::CH_ZERO,        32'h0000_0000, 1'b0, '0},
        '{fsp_pkg::CH_STAR,        32'h8000_0000, 1'b0, '0},
        '{fsp_pkg::CH_DOT,         32'h0000_0000, 1'b0, '0},
        '{fsp_pkg::CH_STAR,        32'h8000_0000, 1'b0, '0},
        '{fsp_pkg::CH_DOT,         32'h7FFF_FFFF, 1'b1,
          fsp_pkg::out_item_t'{fsp_pkg::SPEC_OTHER, 1'b1, 1'b1, 1'b1, fsp_pkg::MAX31,
                               1'b0, 32'h8000_0000, 1'b0}},
        '{fsp_pkg::CH_PERCENT,     32'h0000_0000, 1'b0, '0},
        '{fsp_pkg::CH_ZERO + 8'd2, 32'h0000_0000, 1'b0, '0},
        '{fsp_pkg::CH_ZERO + 8'd1, 32'h0000_0000, 1'b0, '0},
        '{fsp_pkg::CH_ZERO + 8'd4, 32'h0000_0000, 1'b0, '0},
        '{fsp_pkg::CH_ZERO + 8'd7, 32'h0000_0000, 1'b0, '0},
        '{fsp_pkg::CH_ZERO + 8'd4, 32'h0000_0000, 1'b0, '0},
        '{fsp_pkg::CH_ZERO + 8'd8, 32'h0000_0000, 1'b0, '0},
        '{fsp_pkg::CH_ZERO + 8'd3, 32'h0000_0000, 1'b0, '0},
        '{fsp_pkg::CH_ZERO + 8'd6, 32'h0000_0000, 1'b0, '0},
        '{fsp_pkg::CH_ZERO + 8'd4, 32'h0000_0000, 1'b0, '0},
        '{fsp_pkg::CH_ZERO + 8'd8, 32'h0000_0000, 1'b1,
          fsp_pkg::out_item_t'{fsp_pkg::SPEC_OTHER, 1'b0, 1'b0, 1'b0, 31'd0, 1'b0,
                               32'd0, 1'b1}},
        '{fsp_pkg::CH_MINUS,       32'h0000_0000, 1'b0, '0},
        '{fsp_pkg::CH_ZERO + 8'd5, 32'h0000_0000, 1'b0, '0},
        '{fsp_pkg::CH_MINUS,       32'h0000_0000, 1'b1,
          fsp_pkg::out_item_t'{fsp_pkg::SPEC_OTHER, 1'b0, 1'b0, 1'b1, 31'd5, 1'b0,
                               32'd0, 1'b0}},
        '{fsp_pkg::CH_PERCENT,     32'h0000_0000, 1'b0, '0},
        '{fsp_pkg::CH_DOT,         32'h0000_0000, 1'b0, '0},
        '{fsp_pkg::CH_NUL,         32'h0000_0000, 1'b1,
          fsp_pkg::out_item_t'{fsp_pkg::SPEC_NUL, 1'b0, 1'b0, 1'b0, 31'd0, 1'b1,
                               32'd0, 1'b0}}
    };

    function automatic fsp_pkg::spec_code_t spec_class(logic [7:0] c);
        case (c)
            fsp_pkg::CH_LOW_C:   return fsp_pkg::SPEC_C;
            fsp_pkg::CH_LOW_S:   return fsp_pkg::SPEC_S;
            fsp_pkg::CH_LOW_P:   return fsp_pkg::SPEC_P;
            fsp_pkg::CH_LOW_D,
            fsp_pkg::CH_LOW_I:   return fsp_pkg::SPEC_DI;
            fsp_pkg::CH_LOW_U:   return fsp_pkg::SPEC_U;
            fsp_pkg::CH_LOW_X:   return fsp_pkg::SPEC_LOW_X;
            fsp_pkg::CH_UP_X:    return fsp_pkg::SPEC_UP_X;
            fsp_pkg::CH_NUL:     return fsp_pkg::SPEC_NUL;
            fsp_pkg::CH_PERCENT: return fsp_pkg::SPEC_PERCENT;
            default:             return fsp_pkg::SPEC_OTHER;
        endcase
    endfunction

    function automatic void clear_spec();
        spec_left  = 1'b0;
        spec_zero  = 1'b0;
        width_seen = 1'b0;
        width_val  = '0;
        prec_seen  = 1'b0;
        prec_val   = '0;
    endfunction

    // steps the predictor by one character; emitted tells whether a spec came out
    task automatic parse_char(input fsp_pkg::in_item_t it, output bit emitted,
                              output fsp_pkg::out_item_t r);
        logic [7:0]  c;
        logic [31:0] star;
        logic [63:0] acc;
        bit          digit;
        bit          done;
        bit          ovf;
        c       = it.ch;
        star    = it.star_value;
        digit   = (c >= fsp_pkg::CH_ZERO) && (c <= fsp_pkg::CH_NINE);
        done    = 1'b0;
        ovf     = 1'b0;
        emitted = 1'b0;
        r       = '0;
        case (parse_phase)
            fsp_pkg::PH_FLAGS:
            begin
                if (c == fsp_pkg::CH_MINUS)
                    spec_left = 1'b1;
                else if (c == fsp_pkg::CH_ZERO)
                    spec_zero = 1'b1;
                else if (c == fsp_pkg::CH_STAR)
                begin
                    width_seen = 1'b1;
                    if (star[31])
                    begin
                        spec_left = 1'b1;
                        width_val = (star == 32'h8000_0000) ? fsp_pkg::MAX31 : 31'(-star);
                    end
                    else
                        width_val = star[30:0];
                    parse_phase = fsp_pkg::PH_AFTERW;
                end
                else if (digit)
                begin
                    width_seen  = 1'b1;
                    width_val   = 31'(c - fsp_pkg::CH_ZERO);
                    parse_phase = fsp_pkg::PH_WDIG;
                end
                else if (c == fsp_pkg::CH_DOT)
                    parse_phase = fsp_pkg::PH_PSTART;
                else
                    done = 1'b1;
            end
            fsp_pkg::PH_WDIG:
            begin
                if (digit)
                begin
                    acc = 64'(width_val) * 64'd10 + 64'(c - fsp_pkg::CH_ZERO);
                    if (acc > 64'(fsp_pkg::MAX31))
                        ovf = 1'b1;
                    else
                        width_val = acc[30:0];
                end
                else if (c == fsp_pkg::CH_DOT)
                    parse_phase = fsp_pkg::PH_PSTART;
                else
                    done = 1'b1;
            end
            fsp_pkg::PH_AFTERW:
            begin
                if (c == fsp_pkg::CH_DOT)
                    parse_phase = fsp_pkg::PH_PSTART;
                else
                    done = 1'b1;
            end
            fsp_pkg::PH_PSTART:
            begin
                if (c == fsp_pkg::CH_STAR)
                begin
                    prec_val    = star;
                    prec_seen   = !star[31];
                    parse_phase = fsp_pkg::PH_AFTERP;
                end
                else
                begin
                    prec_seen = 1'b1;
                    prec_val  = '0;
                    if (digit)
                    begin
                        prec_val    = 32'(c - fsp_pkg::CH_ZERO);
                        parse_phase = fsp_pkg::PH_PDIG;
                    end
                    else
                        done = 1'b1;
                end
            end
            fsp_pkg::PH_PDIG:
            begin
                if (digit)
                begin
                    acc = 64'(prec_val) * 64'd10 + 64'(c - fsp_pkg::CH_ZERO);
                    if (acc > 64'(fsp_pkg::MAX31))
                        ovf = 1'b1;
                    else
                        prec_val = acc[31:0];
                end
                else
                    done = 1'b1;
            end
            fsp_pkg::PH_AFTERP:
                done = 1'b1;
            default:
            begin
                // introducer: taken unchecked
                clear_spec();
                parse_phase = fsp_pkg::PH_FLAGS;
            end
        endcase
        if (done)
        begin
            r.spec_code     = spec_class(c);
            r.left_align    = spec_left;
            r.zero_pad      = spec_zero;
            r.has_width     = width_seen;
            r.width         = width_val;
            r.has_precision = prec_seen;
            r.precision     = prec_val;
            parse_phase     = fsp_pkg::PH_IDLE;
            emitted         = 1'b1;
        end
        if (ovf)
        begin
            r.spec_code      = fsp_pkg::SPEC_OTHER;
            r.overflow_error = 1'b1;
            clear_spec();
            parse_phase      = fsp_pkg::PH_IDLE;
            emitted          = 1'b1;
        end
    endtask

    function automatic void check_field(string name, longint want, longint got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    function automatic void check_spec(fsp_pkg::out_item_t got);
        fsp_pkg::out_item_t want;
        if (pending_specs.size() == 0)
        begin
            $error("spec result with none expected: code %0d", got.spec_code);
            mismatches++;
            return;
        end
        want = pending_specs.pop_front();
        check_field("spec_code", want.spec_code, got.spec_code);
        check_field("left_align", want.left_align, got.left_align);
        check_field("zero_pad", want.zero_pad, got.zero_pad);
        check_field("has_width", want.has_width, got.has_width);
        check_field("width", want.width, got.width);
        check_field("has_precision", want.has_precision, got.has_precision);
        check_field("precision", longint'($signed(want.precision)),
                    longint'($signed(got.precision)));
        check_field("overflow_error", want.overflow_error, got.overflow_error);
    endfunction

    // one transfer on chars; the result is predicted at acceptance
    task automatic send_char(input fsp_pkg::in_item_t it, input bit typed,
                             input fsp_pkg::out_item_t want);
        int                 gap;
        bit                 emitted;
        fsp_pkg::out_item_t r;
        gap = ((chars_sent / 40) % 4 == 3) ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            chars_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        chars_if.valid <= 1'b1;
        chars_if.data  <= it;
        do
            @(posedge clk);
        while (!chars_if.ready);
        parse_char(it, emitted, r);
        if (emitted)
            pending_specs.push_back(typed ? want : r);
        chars_sent++;
    endtask

    task automatic send_byte(input logic [7:0] c);
        logic [31:0] star;
        case ($urandom_range(0, 7))
            0:       star = 32'h8000_0000;
            1:       star = 32'h7FFF_FFFF;
            2:       star = 32'hFFFF_FFFF;
            3:       star = 32'h0000_0000;
            4:       star = $urandom_range(0, 99);
            5:       star = -32'($urandom_range(1, 99));
            default: star = $urandom;
        endcase
        send_char(fsp_pkg::in_item_t'{ch: c, star_value: star}, 1'b0, '0);
    endtask

    task automatic send_number();
        string digits;
        case ($urandom_range(0, 5))
            0:       digits = "2147483647";
            1:       digits = "2147483648";
            2:       digits = $sformatf("%0d%05d", $urandom_range(1, 999999),
                                        $urandom_range(0, 99999));
            default: digits = $sformatf("%0d", $urandom_range(1, 999));
        endcase
        for (int i = 0; i < digits.len(); i++)
            send_byte(digits[i]);
    endtask

    task automatic send_random_spec();
        send_byte(8'($urandom_range(0, 255)));
        repeat ($urandom_range(0, 3))
            send_byte($urandom_range(0, 1) ? fsp_pkg::CH_MINUS : fsp_pkg::CH_ZERO);
        case ($urandom_range(0, 2))
            1:       send_number();
            2:       send_byte(fsp_pkg::CH_STAR);
            default: ;
        endcase
        if ($urandom_range(0, 1))
        begin
            send_byte(fsp_pkg::CH_DOT);
            case ($urandom_range(0, 3))
                1, 2:    send_number();
                3:       send_byte(fsp_pkg::CH_STAR);
                default: ;
            endcase
        end
        case ($urandom_range(0, 14))
            0:       send_byte(fsp_pkg::CH_LOW_C);
            1:       send_byte(fsp_pkg::CH_LOW_S);
            2:       send_byte(fsp_pkg::CH_LOW_P);
            3:       send_byte(fsp_pkg::CH_LOW_D);
            4:       send_byte(fsp_pkg::CH_LOW_I);
            5:       send_byte(fsp_pkg::CH_LOW_U);
            6:       send_byte(fsp_pkg::CH_LOW_X);
            7:       send_byte(fsp_pkg::CH_UP_X);
            8:       send_byte(fsp_pkg::CH_NUL);
            9:       send_byte(fsp_pkg::CH_PERCENT);
            10:      send_byte(fsp_pkg::CH_DOT);
            11:      send_byte(fsp_pkg::CH_MINUS);
            12:      send_byte(fsp_pkg::CH_STAR);
            default: send_byte(8'($urandom_range(0, 255)));
        endcase
    endtask

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // result side: random stall before each transfer, with stall-free stretches
    initial
    begin
        int stall;
        specs_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = ((specs_seen / 25) % 3 == 2) ? 0 : $urandom_range(0, 12);
            if (stall > 0)
            begin
                specs_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            specs_if.ready <= 1'b1;
            do
                @(posedge clk);
            while (!specs_if.valid);
            check_spec(specs_if.data);
            specs_seen++;
        end
    end

    initial
    begin
        bit drained;
        drained        = 1'b0;
        rst_n          <= 1'b0;
        chars_if.valid <= 1'b0;
        chars_if.data  <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed[i])
            send_char(fsp_pkg::in_item_t'{ch: directed[i].ch, star_value: directed[i].star},
                      directed[i].typed, directed[i].want);

        while (chars_sent < CHAR_COUNT)
        begin
            if (!drained && chars_sent >= CHAR_COUNT / 2)
            begin
                // hold off until every spec in flight has come out
                drained = 1'b1;
                chars_if.valid <= 1'b0;
                do
                    @(posedge clk);
                while (pending_specs.size() != 0);
            end
            if ($urandom_range(0, 99) < 85)
                send_random_spec();
            else
                repeat ($urandom_range(1, 6))
                    send_byte(8'($urandom_range(0, 255)));
        end

        chars_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_specs.size() != 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
